>>> rtl/rtsg_pkg.sv
// Shared types and constants of the ramp-then-sine rate generator.
// Used by the divider, the top level and the port checker; no dependencies.
package rtsg_pkg;

   localparam int RATE_W      = 24;
   localparam int PHASE_W     = 32;
   localparam int RAMP_W      = 16;
   localparam int COUNT_W     = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int Q30_W       = 31;
   localparam int FRAC_W      = 30;
   localparam int PROD_W      = 2 * Q30_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_RATE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AMPLITUDE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_SAMPLES = 2'd3;

   localparam int DIV_DEN_W = RAMP_W;
   localparam int DIV_QUO_W = 32;
   localparam int DIV_NUM_W = DIV_QUO_W + DIV_DEN_W;

   typedef struct packed {
      logic                 done;
      logic [DIV_QUO_W-1:0] quotient;
      logic [DIV_DEN_W-1:0] remainder;
   } div_status_type;

   localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;
   localparam logic signed [63:0] HALF_Q30    = 64'sd536870912;
   localparam logic        [63:0] PI_HALF_Q30 = 64'd1686629713;

   localparam logic [63:0] SIN_SERIES_DIV [1:7] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
   };
   localparam logic [63:0] EXP_SERIES_DIV [1:12] = '{
      64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6,
      64'd7, 64'd8, 64'd9, 64'd10, 64'd11, 64'd12
   };

endpackage

>>> rtl/rtsg_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rtsg_pkg; the caller guarantees the upper dividend part is below the divisor.
module rtsg_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rtsg_pkg::DIV_NUM_W-1:0] dividend,
   input  logic [rtsg_pkg::DIV_DEN_W-1:0] divisor,
   output rtsg_pkg::div_status_type       status
);
   import rtsg_pkg::*;

   localparam int CNT_W = $clog2(DIV_QUO_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] dvs_ff, dvs_in;
   logic [DIV_QUO_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0]   partial;
   logic [DIV_DEN_W:0]   trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      partial  = {rem_ff, quo_ff[DIV_QUO_W-1]};
      trial    = partial - {1'b0, dvs_ff};
      if (start) begin
         rem_in   = dividend[DIV_NUM_W-1 -: DIV_DEN_W];
         quo_in   = dividend[DIV_QUO_W-1:0];
         dvs_in   = divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIV_DEN_W]) begin
            rem_in = trial[DIV_DEN_W-1:0];
         end else begin
            rem_in = partial[DIV_DEN_W-1:0];
         end
         quo_in   = {quo_ff[DIV_QUO_W-2:0], ~trial[DIV_DEN_W]};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(DIV_QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign status.done      = done_ff;
   assign status.quotient  = quo_ff;
   assign status.remainder = rem_ff;

endmodule

>>> rtl/ramp_then_sine_rate_generator_top.sv
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_tick
// rsp      out        rsp_valid/rsp_stall  rsp_yaw_rate, rsp_in_ramp
// csr      in         csr_write            csr_index, csr_wdata
//
// A ramp sample passes through the shared 32-step divider, which runs once for the table index
// and once for the interpolation, but only for the index at ramp end. An oscillation sample
// goes through the shared multiplier and skips the interpolation at a quarter-wave peak, and a
// zero ramp goes straight to scaling. A transaction with tick low yields no result.
// req_stall is high from a tick transaction until its result enters the output register,
// which waits while a stalled result still occupies it.
// Reset is synchronous and clears state, CSR registers, sample counter, phase and rsp_valid; the tables are ROMs.
// Depends on rtsg_pkg and rtsg_div.
module ramp_then_sine_rate_generator_top #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int EASE_TABLE_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_tick,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [rtsg_pkg::RATE_W-1:0] rsp_yaw_rate,
   output logic                              rsp_in_ramp,
   input  logic                              csr_write,
   input  logic [rtsg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rtsg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rtsg_pkg::*;

   localparam int SINE_AW = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int EASE_AW = $clog2(EASE_TABLE_DEPTH + 1);
   localparam int IDX_W   = (SINE_AW > EASE_AW) ? SINE_AW : EASE_AW;

   typedef logic [Q30_W-1:0] sine_rom_type [0:SINE_TABLE_DEPTH];
   typedef logic [Q30_W-1:0] ease_rom_type [0:EASE_TABLE_DEPTH];

   function automatic logic [63:0] clamp_q30(input logic signed [63:0] v);
      if (v < 64'sd0) begin
         return 64'd0;
      end
      if (v > ONE_Q30) begin
         return $unsigned(ONE_Q30);
      end
      return $unsigned(v);
   endfunction

   function automatic logic [Q30_W-1:0] sine_q30(input logic [63:0] x);
      logic [63:0]        term;
      logic signed [63:0] sum;
      term = x;
      sum  = $signed(x);
      for (int k = 1; k <= 7; k++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / SIN_SERIES_DIV[k];
         if (k[0]) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      return Q30_W'(clamp_q30(sum));
   endfunction

   function automatic logic [63:0] exp_neg_q30(input logic [63:0] j);
      logic [63:0]        u;
      logic [63:0]        term;
      logic [63:0]        v;
      logic signed [63:0] sum;
      u    = (j << 29) / EASE_TABLE_DEPTH;
      term = $unsigned(ONE_Q30);
      sum  = ONE_Q30;
      for (int k = 1; k <= 12; k++) begin
         term = ((term * u) >> 30) / EXP_SERIES_DIV[k];
         if (k[0]) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      v = clamp_q30(sum);
      for (int n = 0; n < 3; n++) begin
         v = (v * v + $unsigned(HALF_Q30)) >> 30;
      end
      return v;
   endfunction

   localparam logic [63:0] EASE_END      = exp_neg_q30(64'(EASE_TABLE_DEPTH));
   localparam logic [63:0] EASE_DEN      = $unsigned(ONE_Q30) - EASE_END;
   localparam logic [63:0] EASE_DEN_HALF = EASE_DEN / 2;

   function automatic sine_rom_type build_sine();
      sine_rom_type tab;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         tab[i] = sine_q30((PI_HALF_Q30 * 64'(i)) / SINE_TABLE_DEPTH);
      end
      return tab;
   endfunction

   function automatic ease_rom_type build_ease();
      ease_rom_type tab;
      logic [63:0]  e;
      logic [63:0]  num;
      for (int i = 0; i <= EASE_TABLE_DEPTH; i++) begin
         e      = exp_neg_q30(64'(i));
         num    = (e > EASE_END) ? e - EASE_END : 64'd0;
         tab[i] = Q30_W'(clamp_q30($signed((num * $unsigned(ONE_Q30) + EASE_DEN_HALF)
                                           / EASE_DEN)));
      end
      return tab;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine();
   localparam ease_rom_type EASE_ROM = build_ease();

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POS_MUL,
      ST_INDEX,
      ST_INDEX_DIV,
      ST_READ_LO,
      ST_READ_HI,
      ST_DIFF,
      ST_DIFF_MUL,
      ST_FRAC,
      ST_FRAC_DIV,
      ST_INTERP,
      ST_SCALE,
      ST_ROUND
   } state_type;

   state_type                 state_ff, state_in;
   logic signed [RATE_W-1:0]  start_rate_ff, start_rate_in;
   logic signed [RATE_W-1:0]  amplitude_ff, amplitude_in;
   logic [PHASE_W-1:0]        phase_step_ff, phase_step_in;
   logic [RAMP_W-1:0]         ramp_samples_ff, ramp_samples_in;
   logic [COUNT_W-1:0]        sample_counter_ff, sample_counter_in;
   logic [PHASE_W-1:0]        phase_ff, phase_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [RATE_W-1:0]  rsp_yaw_rate_ff, rsp_yaw_rate_in;
   logic                      rsp_in_ramp_ff, rsp_in_ramp_in;
   logic                      ramp_ff, ramp_in;
   logic                      tneg_ff, tneg_in;
   logic                      dneg_ff, dneg_in;
   logic [Q30_W-1:0]          op_ff, op_in;
   logic [PROD_W-1:0]         mul_ff, mul_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [FRAC_W-1:0]         frac_ff, frac_in;
   logic [Q30_W-1:0]          base_ff, base_in;
   logic [Q30_W-1:0]          mag_ff, mag_in;
   logic [Q30_W-1:0]          q_ff, q_in;
   logic [Q30_W-1:0]          s_ff, s_in;
   logic [Q30_W-1:0]          sine_rd_ff;
   logic [Q30_W-1:0]          ease_rd_ff;

   logic                      div_start;
   div_status_type            div_status;
   logic [Q30_W-1:0]          mul_a, mul_b;
   logic [PROD_W-1:0]         mul_prod;
   logic                      at_end;
   logic [IDX_W-1:0]          rd_idx;
   logic [SINE_AW-1:0]        sine_addr;
   logic [EASE_AW-1:0]        ease_addr;
   logic [Q30_W-1:0]          rom_data;
   logic signed [RATE_W-1:0]  rate_sel;
   logic [RATE_W-1:0]         rate_mag;
   logic [Q30_W-1:0]          pos_lo;
   logic [Q30_W:0]            diff;
   logic signed [Q30_W+1:0]   interp;
   logic [PROD_W-1:0]         rounded;
   logic [RATE_W-1:0]         r_mag;
   logic                      out_neg;

   rtsg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_ff[DIV_NUM_W-1:0]),
      .divisor  (ramp_samples_ff),
      .status   (div_status)
   );

   assign at_end = ramp_ff ? (idx_ff == IDX_W'(EASE_TABLE_DEPTH))
                           : (idx_ff == IDX_W'(SINE_TABLE_DEPTH));
   assign rd_idx = (state_ff == ST_READ_HI && !at_end) ? idx_ff + 1'b1 : idx_ff;
   assign sine_addr = ramp_ff ? '0 : rd_idx[SINE_AW-1:0];
   assign ease_addr = ramp_ff ? rd_idx[EASE_AW-1:0] : '0;
   assign rom_data  = ramp_ff ? ease_rd_ff : sine_rd_ff;

   always_ff @(posedge clock) begin
      sine_rd_ff <= SINE_ROM[sine_addr];
      ease_rd_ff <= EASE_ROM[ease_addr];
   end

   assign rate_sel = ramp_ff ? start_rate_ff : amplitude_ff;
   assign rate_mag = rate_sel[RATE_W-1] ? RATE_W'(-rate_sel) : RATE_W'(rate_sel);
   assign pos_lo   = {1'b0, phase_ff[FRAC_W-1:0]};

   always_comb begin
      unique case (state_ff)
         ST_POS_MUL: begin
            mul_a = op_ff;
            mul_b = ramp_ff ? Q30_W'(EASE_TABLE_DEPTH) : Q30_W'(SINE_TABLE_DEPTH);
         end
         ST_DIFF_MUL: begin
            mul_a = mag_ff;
            mul_b = {1'b0, frac_ff};
         end
         default: begin
            mul_a = Q30_W'(rate_mag);
            mul_b = s_ff;
         end
      endcase
   end

   assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign diff     = {1'b0, rom_data} - {1'b0, base_ff};
   assign interp   = dneg_ff ? $signed({2'b00, base_ff}) - $signed({2'b00, q_ff})
                             : $signed({2'b00, base_ff}) + $signed({2'b00, q_ff});
   assign rounded  = mul_ff + PROD_W'($unsigned(HALF_Q30));
   assign r_mag    = rounded[FRAC_W +: RATE_W];
   assign out_neg  = rate_sel[RATE_W-1] ^ tneg_ff;

   always_comb begin
      state_in          = state_ff;
      start_rate_in     = start_rate_ff;
      amplitude_in      = amplitude_ff;
      phase_step_in     = phase_step_ff;
      ramp_samples_in   = ramp_samples_ff;
      sample_counter_in = sample_counter_ff;
      phase_in          = phase_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_yaw_rate_in   = rsp_yaw_rate_ff;
      rsp_in_ramp_in    = rsp_in_ramp_ff;
      ramp_in           = ramp_ff;
      tneg_in           = tneg_ff;
      dneg_in           = dneg_ff;
      op_in             = op_ff;
      mul_in            = mul_ff;
      idx_in            = idx_ff;
      frac_in           = frac_ff;
      base_in           = base_ff;
      mag_in            = mag_ff;
      q_in              = q_ff;
      s_in              = s_ff;
      div_start         = 1'b0;

      if (csr_write) begin
         unique case (csr_index)
            CSR_START_RATE:   start_rate_in   = csr_wdata[RATE_W-1:0];
            CSR_AMPLITUDE:    amplitude_in    = csr_wdata[RATE_W-1:0];
            CSR_PHASE_STEP:   phase_step_in   = csr_wdata[PHASE_W-1:0];
            CSR_RAMP_SAMPLES: ramp_samples_in = csr_wdata[RAMP_W-1:0];
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_tick) begin
               if (sample_counter_ff != '1) begin
                  sample_counter_in = sample_counter_ff + 1'b1;
               end
               if (sample_counter_ff <= COUNT_W'(ramp_samples_ff)) begin
                  ramp_in  = 1'b1;
                  tneg_in  = 1'b0;
                  phase_in = '0;
                  op_in    = Q30_W'(sample_counter_ff[RAMP_W-1:0]);
                  if (ramp_samples_ff == '0) begin
                     s_in     = '0;
                     state_in = ST_SCALE;
                  end else begin
                     state_in = ST_POS_MUL;
                  end
               end else begin
                  ramp_in  = 1'b0;
                  tneg_in  = phase_ff[PHASE_W-1];
                  op_in    = phase_ff[PHASE_W-2] ? Q30_W'(ONE_Q30) - pos_lo : pos_lo;
                  phase_in = phase_ff + phase_step_ff;
                  state_in = ST_POS_MUL;
               end
            end
         end
         ST_POS_MUL: begin
            mul_in   = mul_prod;
            state_in = ST_INDEX;
         end
         ST_INDEX: begin
            if (ramp_ff) begin
               div_start = 1'b1;
               state_in  = ST_INDEX_DIV;
            end else begin
               idx_in   = mul_ff[FRAC_W +: IDX_W];
               frac_in  = mul_ff[FRAC_W-1:0];
               state_in = ST_READ_LO;
            end
         end
         ST_INDEX_DIV: begin
            if (div_status.done) begin
               idx_in   = div_status.quotient[IDX_W-1:0];
               frac_in  = FRAC_W'(div_status.remainder);
               state_in = ST_READ_LO;
            end
         end
         ST_READ_LO: begin
            state_in = ST_READ_HI;
         end
         ST_READ_HI: begin
            base_in = rom_data;
            if (at_end) begin
               s_in     = rom_data;
               state_in = ST_SCALE;
            end else begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            dneg_in  = diff[Q30_W];
            mag_in   = diff[Q30_W] ? Q30_W'(-diff) : diff[Q30_W-1:0];
            state_in = ST_DIFF_MUL;
         end
         ST_DIFF_MUL: begin
            mul_in   = mul_prod;
            state_in = ST_FRAC;
         end
         ST_FRAC: begin
            if (ramp_ff) begin
               div_start = 1'b1;
               state_in  = ST_FRAC_DIV;
            end else begin
               q_in     = mul_ff[FRAC_W +: Q30_W];
               state_in = ST_INTERP;
            end
         end
         ST_FRAC_DIV: begin
            if (div_status.done) begin
               q_in     = div_status.quotient[Q30_W-1:0];
               state_in = ST_INTERP;
            end
         end
         ST_INTERP: begin
            if (interp[Q30_W+1]) begin
               s_in = '0;
            end else if (interp > $signed((Q30_W+2)'(ONE_Q30))) begin
               s_in = Q30_W'(ONE_Q30);
            end else begin
               s_in = interp[Q30_W-1:0];
            end
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            mul_in   = mul_prod;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               if (out_neg) begin
                  rsp_yaw_rate_in = RATE_W'(-r_mag);
               end else if (r_mag[RATE_W-1]) begin
                  rsp_yaw_rate_in = {1'b0, {(RATE_W-1){1'b1}}};
               end else begin
                  rsp_yaw_rate_in = r_mag;
               end
               rsp_in_ramp_in = ramp_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         start_rate_ff     <= '0;
         amplitude_ff      <= '0;
         phase_step_ff     <= '0;
         ramp_samples_ff   <= '0;
         sample_counter_ff <= '0;
         phase_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         start_rate_ff     <= start_rate_in;
         amplitude_ff      <= amplitude_in;
         phase_step_ff     <= phase_step_in;
         ramp_samples_ff   <= ramp_samples_in;
         sample_counter_ff <= sample_counter_in;
         phase_ff          <= phase_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      rsp_yaw_rate_ff <= rsp_yaw_rate_in;
      rsp_in_ramp_ff  <= rsp_in_ramp_in;
      ramp_ff         <= ramp_in;
      tneg_ff         <= tneg_in;
      dneg_ff         <= dneg_in;
      op_ff           <= op_in;
      mul_ff          <= mul_in;
      idx_ff          <= idx_in;
      frac_ff         <= frac_in;
      base_ff         <= base_in;
      mag_ff          <= mag_in;
      q_ff            <= q_in;
      s_ff            <= s_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_yaw_rate = rsp_yaw_rate_ff;
   assign rsp_in_ramp  = rsp_in_ramp_ff;

endmodule

>>> rtl/rtsg_checker.sv
// Port-level checker for the ramp-then-sine rate generator, with its bind statement.
// Depends on rtsg_pkg and watches the ports of ramp_then_sine_rate_generator_top.
module rtsg_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               req_tick,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [rtsg_pkg::RATE_W-1:0] rsp_yaw_rate,
   input logic                               rsp_in_ramp
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_yaw_rate) && $stable(rsp_in_ramp))
      else $error("stalled result transaction changed or dropped");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_tick |=> req_stall)
      else $error("tick transaction did not start the sample sequence");

   a_idle_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_tick |=> !req_stall)
      else $error("transaction without tick made the block busy");

   a_result_ends_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $fell(req_stall))
      else $error("result appeared without the end of a sample sequence");

endmodule

bind ramp_then_sine_rate_generator_top rtsg_checker u_rtsg_checker (.*);

>>> dv/ramp_then_sine_rate_generator_top_tb.sv
// Self-checking testbench for ramp_then_sine_rate_generator_top: programs the rate registers,
// sends tick transactions and checks every yaw-rate sample against a bit-exact predictor.
// Depends on rtsg_pkg and the generator RTL.
module ramp_then_sine_rate_generator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rtsg_pkg::*;

   localparam int SINE_DEPTH = 1024;
   localparam int EASE_DEPTH = 256;
   localparam int SETTLE_CYCLES = 100;
   localparam int QUIET_LIMIT = 4000;
   localparam int TICKS_PER_REGIME = 222;
   localparam longint UNIT = ONE_Q30;
   localparam longint HALF = HALF_Q30;
   localparam longint FRAC_MASK = UNIT - 1;
   localparam longint unsigned PI_HALF = PI_HALF_Q30;
   localparam longint RATE_MAX = 2 ** (RATE_W - 1) - 1;
   localparam longint RATE_MIN = -(2 ** (RATE_W - 1));

   typedef struct packed {
      logic signed [RATE_W-1:0] yaw_rate;
      logic                     in_ramp;
   } rate_sample_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_tick = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [RATE_W-1:0]      rsp_yaw_rate;
   logic                          rsp_in_ramp;
   logic                          csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata = '0;

   longint                        sine_quarter [0:SINE_DEPTH];
   longint                        ease_fall [0:EASE_DEPTH];
   logic signed [RATE_W-1:0]      cfg_start_rate = '0;
   logic signed [RATE_W-1:0]      cfg_amplitude = '0;
   logic [PHASE_W-1:0]            cfg_phase_step = '0;
   logic [RAMP_W-1:0]             cfg_ramp_len = '0;
   logic [COUNT_W-1:0]            sample_count = '0;
   logic [PHASE_W-1:0]            phase_acc = '0;

   bit                            tick_backlog [$];
   rate_sample_type               expected_samples [$];
   int                            send_idle_pct = 29;
   int                            recv_idle_pct = 84;
   int                            mismatch_count = 0;
   int                            quiet_cycles = 0;

   ramp_then_sine_rate_generator_top #(
      .SINE_TABLE_DEPTH(SINE_DEPTH),
      .EASE_TABLE_DEPTH(EASE_DEPTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_tick     (req_tick),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_yaw_rate (rsp_yaw_rate),
      .rsp_in_ramp  (rsp_in_ramp),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint q30_clamp(longint v);
      if (v < 0) return 0;
      if (v > UNIT) return UNIT;
      return v;
   endfunction

   function automatic longint series_sine(longint unsigned x);
      longint unsigned term;
      longint          sum;
      int              k;
      term = x;
      sum = longint'(x);
      for (k = 1; k <= 7; k++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum -= longint'(term);
         else sum += longint'(term);
      end
      return q30_clamp(sum);
   endfunction

   function automatic longint unsigned series_exp_neg(longint unsigned j);
      longint unsigned u;
      longint unsigned term;
      longint unsigned v;
      longint          sum;
      int              k;
      u = (j << 29) / EASE_DEPTH;
      term = UNIT;
      sum = UNIT;
      for (k = 1; k <= 12; k++) begin
         term = ((term * u) >> 30) / k;
         if (k % 2 == 1) sum -= longint'(term);
         else sum += longint'(term);
      end
      v = q30_clamp(sum);
      repeat (3) v = (v * v + HALF) >> 30;
      return v;
   endfunction

   function automatic void fill_tables();
      longint unsigned i;
      longint unsigned e;
      longint unsigned e_end;
      longint unsigned den;
      longint unsigned num;
      for (i = 0; i <= SINE_DEPTH; i++)
         sine_quarter[i] = series_sine((PI_HALF * i) / SINE_DEPTH);
      e_end = series_exp_neg(EASE_DEPTH);
      den = UNIT - e_end;
      for (i = 0; i <= EASE_DEPTH; i++) begin
         e = series_exp_neg(i);
         num = (e > e_end) ? e - e_end : 0;
         ease_fall[i] = q30_clamp(longint'((num * UNIT + den / 2) / den));
      end
   endfunction

   function automatic logic signed [RATE_W-1:0] scale_by_q30(longint rate, longint t);
      bit              neg;
      longint unsigned ma;
      longint unsigned mt;
      longint          r;
      neg = (rate < 0) != (t < 0);
      ma = (rate < 0) ? -rate : rate;
      mt = (t < 0) ? -t : t;
      r = longint'((ma * mt + HALF) >> 30);
      if (neg) r = -r;
      if (r > RATE_MAX) r = RATE_MAX;
      if (r < RATE_MIN) r = RATE_MIN;
      return r[RATE_W-1:0];
   endfunction

   function automatic longint sine_at(logic [PHASE_W-1:0] phase);
      logic [1:0] quad;
      longint     pos;
      longint     prod;
      longint     idx;
      longint     frac;
      longint     d;
      longint     s;
      quad = phase[31:30];
      pos = longint'(phase[29:0]);
      if (quad[0]) pos = UNIT - pos;
      prod = pos * SINE_DEPTH;
      idx = prod >> 30;
      frac = prod & FRAC_MASK;
      if (idx >= SINE_DEPTH) begin
         s = sine_quarter[SINE_DEPTH];
      end else begin
         d = sine_quarter[idx + 1] - sine_quarter[idx];
         s = sine_quarter[idx] + (d * frac) / UNIT;
      end
      s = q30_clamp(s);
      return quad[1] ? -s : s;
   endfunction

   function automatic longint ease_at(logic [COUNT_W-1:0] n, logic [RAMP_W-1:0] r);
      longint rl;
      longint prod;
      longint idx;
      longint rem;
      longint d;
      rl = longint'(r);
      prod = longint'(n) * EASE_DEPTH;
      idx = prod / rl;
      rem = prod % rl;
      if (idx >= EASE_DEPTH) return ease_fall[EASE_DEPTH];
      d = ease_fall[idx + 1] - ease_fall[idx];
      return q30_clamp(ease_fall[idx] + (d * rem) / rl);
   endfunction

   function automatic void next_sample(bit tick);
      rate_sample_type s;
      longint          gain;
      if (!tick) return;
      if (sample_count <= cfg_ramp_len) begin
         gain = (cfg_ramp_len == 0) ? 0 : ease_at(sample_count, cfg_ramp_len);
         s.yaw_rate = scale_by_q30(longint'(cfg_start_rate), gain);
         s.in_ramp = 1'b1;
         phase_acc = '0;
      end else begin
         s.yaw_rate = scale_by_q30(longint'(cfg_amplitude), sine_at(phase_acc));
         s.in_ramp = 1'b0;
         phase_acc = phase_acc + cfg_phase_step;
      end
      if (sample_count != '1) sample_count++;
      expected_samples.push_back(s);
   endfunction

   function automatic logic [RATE_W-1:0] pick_rate();
      case ($urandom_range(0, 5))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return '0;
         default: return RATE_W'($urandom());
      endcase
   endfunction

   function automatic logic [PHASE_W-1:0] pick_step();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h4000_0000;
         3: return $urandom_range(1, 1 << 22);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [RAMP_W-1:0] pick_ramp();
      longint span;
      case ($urandom_range(0, 6))
         0: span = 0;
         1: span = 65535;
         2: span = longint'(sample_count) + $urandom_range(0, 40);
         3: span = longint'(sample_count) * $urandom_range(2, 8) + $urandom_range(0, 3);
         4: span = $urandom_range(0, 65535);
         default: span = longint'(sample_count) - $urandom_range(1, 200);
      endcase
      if (span < 0) span = 0;
      if (span > 65535) span = 65535;
      return span[RAMP_W-1:0];
   endfunction

   function automatic int queue_ticks(int count);
      int  high;
      bit  tick;
      high = 0;
      repeat (count) begin
         tick = ($urandom_range(0, 99) >= 15);
         tick_backlog.push_back(tick);
         if (tick) high++;
      end
      return high;
   endfunction

   task automatic wait_idle();
      while (tick_backlog.size() != 0 || expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_START_RATE:   cfg_start_rate = value[RATE_W-1:0];
         CSR_AMPLITUDE:    cfg_amplitude = value[RATE_W-1:0];
         CSR_PHASE_STEP:   cfg_phase_step = value[PHASE_W-1:0];
         CSR_RAMP_SAMPLES: cfg_ramp_len = value[RAMP_W-1:0];
      endcase
   endtask

   task automatic set_generator(input logic [RATE_W-1:0] start, input logic [RATE_W-1:0] amp,
                                input logic [PHASE_W-1:0] step, input logic [RAMP_W-1:0] ramp);
      logic [31:0] junk;
      junk = $urandom();
      write_reg(CSR_START_RATE, {junk[31:24], start});
      write_reg(CSR_AMPLITUDE, {junk[23:16], amp});
      write_reg(CSR_PHASE_STEP, step);
      write_reg(CSR_RAMP_SAMPLES, {junk[15:0], ramp});
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   always @(posedge clock) begin : drive_ticks
      bit fire;
      bit tick;
      if (!reset) begin
         fire = req_valid && !req_stall;
         if (fire) begin
            tick = tick_backlog.pop_front();
            next_sample(tick);
         end
         if (req_valid && !fire) begin
         end else if (tick_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_tick <= tick_backlog[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_samples
      rate_sample_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected sample: yaw_rate %0d in_ramp %0b",
                           rsp_yaw_rate, rsp_in_ramp);
               mismatch_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_yaw_rate !== want.yaw_rate || rsp_in_ramp !== want.in_ramp) begin
                  if (mismatch_count < 10)
                     $display("sample mismatch: expected yaw_rate %0d in_ramp %0b, got %0d %0b",
                              $signed(want.yaw_rate), want.in_ramp, rsp_yaw_rate, rsp_in_ramp);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int regime;
      int high_ticks;
      fill_tables();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // A zero ramp first, then quarter-turn steps that end in the saturating product.
      set_generator(24'h800000, 24'h800000, 32'h4000_0000, 16'd0);
      tick_backlog.push_back(1'b1);
      tick_backlog.push_back(1'b0);
      repeat (4) tick_backlog.push_back(1'b1);

      wait_idle();
      set_generator(24'h7FFFFF, 24'h7FFFFF, 32'hFFFF_FFFF, 16'hFFFF);
      tick_backlog.push_back(1'b1);
      tick_backlog.push_back(1'b1);
      tick_backlog.push_back(1'b0);
      tick_backlog.push_back(1'b1);

      wait_idle();
      set_generator(24'h7FFFFF, 24'h800000, 32'hFFFF_FFFF, RAMP_W'(sample_count + 8));
      repeat (6) tick_backlog.push_back(1'b1);
      tick_backlog.push_back(1'b0);
      repeat (7) tick_backlog.push_back(1'b1);

      for (regime = 0; regime < 3; regime++) begin
         wait_idle();
         case (regime)
            0: begin
               send_idle_pct = 29;
               recv_idle_pct = 84;
            end
            1: begin
               send_idle_pct = 84;
               recv_idle_pct = 29;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         high_ticks = 0;
         while (high_ticks < TICKS_PER_REGIME) begin
            wait_idle();
            set_generator(pick_rate(), pick_rate(), pick_step(), pick_ramp());
            high_ticks += queue_ticks($urandom_range(4, 40));
         end
      end

      wait_idle();
      if (mismatch_count == 0 && expected_samples.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
